@@ hdl/glpg_pkg.sv @@
// Shared types and constants for the grid line point generator.
package glpg_pkg;

    localparam int COORD_W = 6;
    localparam int ERR_W   = 8;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic signed [ERR_W-1:0] err_t;

    typedef struct packed {
        logic load;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic at_end;
    } dp_stat_t;

endpackage

@@ hdl/glpg_in_if.sv @@
// Request channel: start cell, end cell and level of one line.
interface glpg_in_if;
    logic              valid;
    logic              ready;
    glpg_pkg::coord_t  start_x;
    glpg_pkg::coord_t  start_z;
    glpg_pkg::coord_t  end_x;
    glpg_pkg::coord_t  end_z;
    glpg_pkg::coord_t  level_y;

    modport source (output valid, output start_x, output start_z, output end_x,
                    output end_z, output level_y, input ready);
    modport sink   (input valid, input start_x, input start_z, input end_x,
                    input end_z, input level_y, output ready);
endinterface

@@ hdl/glpg_out_if.sv @@
// Point channel: one line cell per word, last marks the end cell.
interface glpg_out_if;
    logic              valid;
    logic              ready;
    glpg_pkg::coord_t  point_x;
    glpg_pkg::coord_t  point_y;
    glpg_pkg::coord_t  point_z;
    logic              last;

    modport source (output valid, output point_x, output point_y, output point_z,
                    output last, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    input last, output ready);
endinterface

@@ hdl/grid_line_point_generator_top.sv @@
// Top level of the grid line point generator.
// Each request word names a start cell, an end cell and a level; the block
// answers with every cell of the Bresenham line from start to end, one point
// word per cycle while the sink is ready, start first, with last set on the
// end cell. A line has at most 64 points, or GRID_SIZE if smaller, paced by
// the single step unit that walks the error term. The next request is taken
// in the cycle the last point of the current line is taken, so lines run back
// to back. Coordinates at or above GRID_SIZE are clamped to GRID_SIZE - 1.
module grid_line_point_generator_top #(
    parameter int GRID_SIZE = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    glpg_in_if.sink     line_in,
    glpg_out_if.source  point_out
);
    import glpg_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    glpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (line_in.valid),
        .in_ready  (line_in.ready),
        .out_valid (point_out.valid),
        .out_ready (point_out.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    glpg_dp #(
        .GRID_SIZE (GRID_SIZE)
    ) u_dp (
        .clk     (clk),
        .cmd     (cmd),
        .stat    (stat),
        .start_x (line_in.start_x),
        .start_z (line_in.start_z),
        .end_x   (line_in.end_x),
        .end_z   (line_in.end_z),
        .level_y (line_in.level_y),
        .point_x (point_out.point_x),
        .point_y (point_out.point_y),
        .point_z (point_out.point_z)
    );

    assign point_out.last = stat.at_end;

endmodule

@@ hdl/glpg_ctrl.sv @@
// Controller: sequences load and walk of one line at a time.
module glpg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  glpg_pkg::dp_stat_t  stat,
    output glpg_pkg::dp_cmd_t   cmd
);
    import glpg_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic state_reg;
    logic state_next;
    logic fin;

    assign out_valid = (state_reg == ST_WALK);
    assign fin       = out_valid && out_ready && stat.at_end;
    assign in_ready  = (state_reg == ST_IDLE) || fin;
    assign cmd.load  = in_valid && in_ready;
    assign cmd.step  = out_valid && out_ready && !stat.at_end;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (cmd.load)
                    state_next = ST_WALK;
                else if (fin)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ hdl/glpg_dp.sv @@
// Datapath: clamps the request, holds the walk position and error term.
module glpg_dp #(
    parameter int GRID_SIZE = 64
) (
    input  logic                clk,
    input  glpg_pkg::dp_cmd_t   cmd,
    output glpg_pkg::dp_stat_t  stat,
    input  glpg_pkg::coord_t    start_x,
    input  glpg_pkg::coord_t    start_z,
    input  glpg_pkg::coord_t    end_x,
    input  glpg_pkg::coord_t    end_z,
    input  glpg_pkg::coord_t    level_y,
    output glpg_pkg::coord_t    point_x,
    output glpg_pkg::coord_t    point_y,
    output glpg_pkg::coord_t    point_z
);
    import glpg_pkg::*;

    localparam coord_t COORD_MAX = (GRID_SIZE >= (1 << COORD_W)) ?
                                   {COORD_W{1'b1}} : COORD_W'(GRID_SIZE - 1);

    coord_t cur_x_reg, cur_z_reg, end_x_reg, end_z_reg, level_reg;
    coord_t span_x_reg, span_z_reg;
    logic   down_x_reg, down_z_reg;
    err_t   err_reg;

    coord_t sx0, sz0, ex0, ez0;
    coord_t span_x_ld, span_z_ld;
    logic signed [ERR_W:0] e2, neg_sz, pos_sx, err_sum;
    logic   x_go, z_go;

    assign sx0 = (start_x > COORD_MAX) ? COORD_MAX : start_x;
    assign sz0 = (start_z > COORD_MAX) ? COORD_MAX : start_z;
    assign ex0 = (end_x > COORD_MAX) ? COORD_MAX : end_x;
    assign ez0 = (end_z > COORD_MAX) ? COORD_MAX : end_z;

    assign span_x_ld = (ex0 > sx0) ? (ex0 - sx0) : (sx0 - ex0);
    assign span_z_ld = (ez0 > sz0) ? (ez0 - sz0) : (sz0 - ez0);

    // e2 = 2 * error, compared against -span_z and span_x
    assign e2     = {err_reg, 1'b0};
    assign pos_sx = $signed({{(ERR_W+1-COORD_W){1'b0}}, span_x_reg});
    assign neg_sz = -$signed({{(ERR_W+1-COORD_W){1'b0}}, span_z_reg});
    assign x_go   = (e2 > neg_sz);
    assign z_go   = (e2 < pos_sx);

    always_comb
    begin
        err_sum = {err_reg[ERR_W-1], err_reg};
        if (x_go)
            err_sum = err_sum + neg_sz;
        if (z_go)
            err_sum = err_sum + pos_sx;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_x_reg  <= sx0;
            cur_z_reg  <= sz0;
            end_x_reg  <= ex0;
            end_z_reg  <= ez0;
            level_reg  <= level_y;
            span_x_reg <= span_x_ld;
            span_z_reg <= span_z_ld;
            down_x_reg <= !(sx0 < ex0);
            down_z_reg <= !(sz0 < ez0);
            err_reg    <= $signed({{(ERR_W-COORD_W){1'b0}}, span_x_ld})
                        - $signed({{(ERR_W-COORD_W){1'b0}}, span_z_ld});
        end
        else if (cmd.step)
        begin
            err_reg <= err_sum[ERR_W-1:0];
            if (x_go)
                cur_x_reg <= down_x_reg ? (cur_x_reg - 1'b1) : (cur_x_reg + 1'b1);
            if (z_go)
                cur_z_reg <= down_z_reg ? (cur_z_reg - 1'b1) : (cur_z_reg + 1'b1);
        end
    end

    assign stat.at_end = (cur_x_reg == end_x_reg) && (cur_z_reg == end_z_reg);
    assign point_x     = cur_x_reg;
    assign point_y     = level_reg;
    assign point_z     = cur_z_reg;

endmodule
